// ----- src/rc_pulse_width_decoder_top_assert.svh -----
// assertion macros shared by the decoder rtl
`ifndef RC_PULSE_WIDTH_DECODER_TOP_ASSERT_SVH
`define RC_PULSE_WIDTH_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every edge out of reset
`define RCPWD_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("rcpwd assertion failed");
// checked on every edge, reset included
`define RCPWD_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("rcpwd assertion failed");
`else
`define RCPWD_ASSERT(lbl, ck, rn, prop)
`define RCPWD_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

// ----- src/rcpwd_pkg.sv -----
package rcpwd_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NCH           = 2;
  localparam int CH_STEER      = 0;
  localparam int CH_THR        = 1;

  // payload widths
  localparam int PW_W    = 16;
  localparam int STEER_W = 10;
  localparam int THR_W   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_INTERVAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_BELOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FROM     = 3'd5;

  localparam logic [PW_W-1:0] RST_STEER_INTERVAL    = 16'd2000;
  localparam logic [PW_W-1:0] RST_THROTTLE_INTERVAL = 16'd16600;
  localparam logic [PW_W-1:0] RST_MIN_PULSE         = 16'd1000;
  localparam logic [PW_W-1:0] RST_MAX_PULSE         = 16'd2000;
  localparam logic [PW_W-1:0] RST_BRAKE_BELOW       = 16'd1100;
  localparam logic [PW_W-1:0] RST_THROTTLE_FROM     = 16'd1500;

  // steering calibration points
  localparam int ST_LOW_W  = 1012;
  localparam int ST_KNEE_W = 1440;
  localparam int ST_HIGH_W = 1860;
  localparam int ST_LOW_V  = 779;
  localparam int ST_KNEE_V = 722;
  localparam int ST_HIGH_V = 639;

  // segment slopes as magnitude / divisor
  localparam int ST_LO_K = ST_LOW_V - ST_KNEE_V;
  localparam int ST_LO_D = ST_KNEE_W - ST_LOW_W;
  localparam int ST_HI_K = ST_KNEE_V - ST_HIGH_V;
  localparam int ST_HI_D = ST_HIGH_W - ST_KNEE_W;

  // reciprocal division, quotient short by at most one
  localparam int REC_SHIFT = 20;
  localparam int ST_LO_R   = (1 << REC_SHIFT) / ST_LO_D;
  localparam int ST_HI_R   = (1 << REC_SHIFT) / ST_HI_D;

  localparam int ST_DMAG_W = 12;
  localparam int ST_MAG_W  = 19;
  localparam int ST_REC_W  = 12;
  localparam int ST_PROD_W = ST_MAG_W + ST_REC_W;
  localparam int ST_Q_W    = 10;

  // largest value the low segment can give (width zero)
  localparam int ST_V_MAX = ST_LOW_V + (ST_LOW_W * ST_LO_K) / ST_LO_D;

  // throttle scaling
  localparam int THR_MAX   = 120;
  localparam int THR_Q_W   = 7;
  localparam int THR_NUM_W = 23;
  localparam logic signed [THR_W-1:0] THR_BRAKE = -8'sd1;

  // pipeline depth up to the last divider step
  localparam int PIPE_LAST = 2 + THR_Q_W;

  typedef struct packed {
    logic st_upd;
    logic th_brake;
    logic th_map;
    logic fresh_s;
    logic fresh_t;
  } item_ctl_t;

endpackage

// ----- src/rcpwd_ifs.sv -----
interface rcpwd_in_if;
  logic valid;
  logic ready;
  logic steer_level;
  logic throttle_level;
  logic clear_flags;

  modport source (output valid, steer_level, throttle_level, clear_flags, input ready);
  modport sink (input valid, steer_level, throttle_level, clear_flags, output ready);
endinterface

interface rcpwd_out_if import rcpwd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STEER_W-1:0]      steering_value;
  logic signed [THR_W-1:0] throttle_value;
  logic                    steering_fresh;
  logic                    throttle_fresh;
  logic                    all_valid;

  modport source (output valid, steering_value, throttle_value, steering_fresh,
                  throttle_fresh, all_valid, input ready);
  modport sink (input valid, steering_value, throttle_value, steering_fresh,
                throttle_fresh, all_valid, output ready);
endinterface

interface rcpwd_cfg_if import rcpwd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/rc_pulse_width_decoder_top.sv -----
// pipeline: an accepted item passes the edge detect stage, then the steering map
//   stages beside a 7-step restoring divider for the throttle scale, and the output reg
// throughput: one item per cycle; a stalled output holds the whole pipeline
// reset: synchronous, active low; clears time base, channel state, output valid and
//   command values, and returns the configuration registers to their defaults
`include "rc_pulse_width_decoder_top_assert.svh"

module rc_pulse_width_decoder_top
  import rcpwd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rcpwd_in_if.sink     in_ch,
  rcpwd_out_if.source  out_ch,
  rcpwd_cfg_if.sink    cfg_ch
);

  // ---------------------------------------------------------------------------
  // configuration registers, written by the user only while the block is idle; not enforced here
  // ---------------------------------------------------------------------------
  logic [PW_W-1:0] steer_int_r;
  logic [PW_W-1:0] thr_int_r;
  logic [PW_W-1:0] min_pulse_r;
  logic [PW_W-1:0] max_pulse_r;
  logic [PW_W-1:0] brake_below_r;
  logic [PW_W-1:0] thr_from_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_int_r   <= RST_STEER_INTERVAL;
      thr_int_r     <= RST_THROTTLE_INTERVAL;
      min_pulse_r   <= RST_MIN_PULSE;
      max_pulse_r   <= RST_MAX_PULSE;
      brake_below_r <= RST_BRAKE_BELOW;
      thr_from_r    <= RST_THROTTLE_FROM;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_STEER_INTERVAL:    steer_int_r   <= cfg_ch.data;
        REG_THROTTLE_INTERVAL: thr_int_r     <= cfg_ch.data;
        REG_MIN_PULSE:         min_pulse_r   <= cfg_ch.data;
        REG_MAX_PULSE:         max_pulse_r   <= cfg_ch.data;
        REG_BRAKE_BELOW:       brake_below_r <= cfg_ch.data;
        REG_THROTTLE_FROM:     thr_from_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // throttle span, registered from the config; zero means no span
  logic [PW_W-1:0] span_r;

  always_ff @(posedge clk) begin
    span_r <= (max_pulse_r > thr_from_r) ? (max_pulse_r - thr_from_r) : '0;
  end

  // ---------------------------------------------------------------------------
  // handshake: one global advance, the output register is the only stall point
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic in_fire;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  // ---------------------------------------------------------------------------
  // stage 0: edge detect, width capture and acceptance per channel
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] now_r;
  logic [NCH-1:0]       last_lvl_r;
  logic [NCH-1:0]       await_r;
  logic [NCH-1:0]       fresh_r;
  logic [TIME_BITS-1:0] rise_r  [NCH];
  logic [TIME_BITS-1:0] stamp_r [NCH];
  logic [PW_W-1:0]      meas_r  [NCH];
  logic [PW_W-1:0]      prev_r  [NCH];

  logic [NCH-1:0]       lvl_c;
  logic [PW_W-1:0]      ivl_c   [NCH];
  logic [PW_W-1:0]      width_c [NCH];
  logic                 rise_c  [NCH];
  logic                 fall_c  [NCH];
  logic                 acc_c   [NCH];
  logic                 upd_c   [NCH];

  assign lvl_c           = {in_ch.throttle_level, in_ch.steer_level};
  assign ivl_c[CH_STEER] = steer_int_r;
  assign ivl_c[CH_THR]   = thr_int_r;

  for (genvar ch = 0; ch < NCH; ch++) begin : g_sense
    logic [TIME_BITS-1:0] rise_dt;
    logic [TIME_BITS-1:0] gap_dt;

    assign rise_c[ch] = lvl_c[ch] && !last_lvl_r[ch];
    // a fall only counts after a captured rise
    assign fall_c[ch] = !lvl_c[ch] && last_lvl_r[ch] && await_r[ch];
    assign rise_dt    = now_r - rise_r[ch];
    assign gap_dt     = now_r - stamp_r[ch];

    // high time saturates at full scale of the width field
    assign width_c[ch] = !fall_c[ch] ? meas_r[ch] :
                         ((|rise_dt[TIME_BITS-1:PW_W]) ? '1 : rise_dt[PW_W-1:0]);

    assign acc_c[ch] = (gap_dt >= {{(TIME_BITS-PW_W){1'b0}}, ivl_c[ch]}) &&
                       (width_c[ch] >= min_pulse_r) && (width_c[ch] <= max_pulse_r);
    // map only when two widths in a row agree
    assign upd_c[ch] = acc_c[ch] && (prev_r[ch] == width_c[ch]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      last_lvl_r <= '0;
      await_r    <= '0;
      fresh_r    <= '0;
      for (int ch = 0; ch < NCH; ch++) begin
        rise_r[ch]  <= '0;
        stamp_r[ch] <= '0;
        meas_r[ch]  <= '0;
        prev_r[ch]  <= '0;
      end
    end else if (in_fire) begin
      now_r <= now_r + 1'b1;
      for (int ch = 0; ch < NCH; ch++) begin
        last_lvl_r[ch] <= lvl_c[ch];
        if (rise_c[ch]) begin
          rise_r[ch]  <= now_r;
          await_r[ch] <= 1'b1;
        end else if (fall_c[ch]) begin
          await_r[ch] <= 1'b0;
        end
        meas_r[ch] <= width_c[ch];
        if (acc_c[ch]) begin
          stamp_r[ch] <= now_r;
          prev_r[ch]  <= width_c[ch];
        end
        // flags go out before the clear of the same item
        fresh_r[ch] <= !in_ch.clear_flags && (fresh_r[ch] || acc_c[ch]);
      end
    end
  end

  // what the rest of the pipe needs to know about this item
  item_ctl_t ctl0;
  logic      th_brake_c;

  assign th_brake_c    = width_c[CH_THR] < brake_below_r;
  assign ctl0.st_upd   = upd_c[CH_STEER];
  assign ctl0.th_brake = upd_c[CH_THR] && th_brake_c;
  assign ctl0.th_map   = upd_c[CH_THR] && !th_brake_c && (width_c[CH_THR] >= thr_from_r);
  assign ctl0.fresh_s  = fresh_r[CH_STEER] || acc_c[CH_STEER];
  assign ctl0.fresh_t  = fresh_r[CH_THR] || acc_c[CH_THR];

  // ---------------------------------------------------------------------------
  // pipeline control: valid bits and per-item control, shifted on advance
  // ---------------------------------------------------------------------------
  logic [PIPE_LAST:1] vld_r;
  item_ctl_t          ctl_r [1:PIPE_LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAST-1:1], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[1] <= ctl0;
      for (int k = 2; k <= PIPE_LAST; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // stage 1: the two widths
  logic [PW_W-1:0] stw1_r;
  logic [PW_W-1:0] thw1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      stw1_r <= width_c[CH_STEER];
      thw1_r <= width_c[CH_THR];
    end
  end

  // ---------------------------------------------------------------------------
  // steering map: distance from the segment start times the slope magnitude,
  // then division by the segment length through a reciprocal and one fix-up
  // ---------------------------------------------------------------------------
  logic              st_hi_c;
  logic              st_neg_c;
  logic [PW_W-1:0]   st_dd_c;
  logic [ST_MAG_W-1:0] st_mag_c;

  assign st_hi_c  = stw1_r > PW_W'(ST_KNEE_W);
  // below the low point the low segment rises above its base value
  assign st_neg_c = stw1_r < PW_W'(ST_LOW_W);
  assign st_dd_c  = st_hi_c  ? (stw1_r - PW_W'(ST_KNEE_W)) :
                    st_neg_c ? (PW_W'(ST_LOW_W) - stw1_r)  :
                               (stw1_r - PW_W'(ST_LOW_W));
  assign st_mag_c = ST_MAG_W'(st_dd_c[ST_DMAG_W-1:0]) *
                    (st_hi_c ? ST_MAG_W'(ST_HI_K) : ST_MAG_W'(ST_LO_K));

  // stage 2
  logic [ST_MAG_W-1:0] st_mag2_r;
  logic                st_hi2_r;
  logic                st_neg2_r;
  logic                st_sat2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      st_mag2_r <= st_mag_c;
      st_hi2_r  <= st_hi_c;
      st_neg2_r <= st_neg_c;
      // far up the high segment the value is clamped to zero anyway
      st_sat2_r <= st_hi_c && (|st_dd_c[PW_W-1:ST_DMAG_W]);
    end
  end

  // stage 3: reciprocal estimate
  logic [ST_PROD_W-1:0] st_prod_c;
  logic [ST_MAG_W-1:0]  st_mag3_r;
  logic [ST_Q_W-1:0]    st_q03_r;
  logic                 st_hi3_r;
  logic                 st_neg3_r;
  logic                 st_sat3_r;

  assign st_prod_c = ST_PROD_W'(st_mag2_r) *
                     (st_hi2_r ? ST_PROD_W'(ST_HI_R) : ST_PROD_W'(ST_LO_R));

  always_ff @(posedge clk) begin
    if (adv) begin
      st_mag3_r <= st_mag2_r;
      st_q03_r  <= st_prod_c[REC_SHIFT +: ST_Q_W];
      st_hi3_r  <= st_hi2_r;
      st_neg3_r <= st_neg2_r;
      st_sat3_r <= st_sat2_r;
    end
  end

  // stage 4: remainder check lifts the estimate by one where needed
  logic [ST_MAG_W-1:0] st_div_c;
  logic [ST_MAG_W-1:0] st_rem_c;
  logic [ST_Q_W-1:0]   st_q4_r;
  logic                st_hi4_r;
  logic                st_neg4_r;
  logic                st_sat4_r;

  assign st_div_c = st_hi3_r ? ST_MAG_W'(ST_HI_D) : ST_MAG_W'(ST_LO_D);
  assign st_rem_c = st_mag3_r - ST_MAG_W'(st_q03_r) * st_div_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      st_q4_r   <= st_q03_r + ST_Q_W'(st_rem_c >= st_div_c);
      st_hi4_r  <= st_hi3_r;
      st_neg4_r <= st_neg3_r;
      st_sat4_r <= st_sat3_r;
    end
  end

  // stage 5: apply to the segment base and clamp at zero
  logic [STEER_W-1:0] st_v_c;
  logic [STEER_W-1:0] stv_r [5:PIPE_LAST];

  always_comb begin
    if (st_sat4_r) begin
      st_v_c = '0;
    end else if (st_hi4_r) begin
      st_v_c = (st_q4_r > ST_Q_W'(ST_KNEE_V)) ? '0 : (STEER_W'(ST_KNEE_V) - st_q4_r);
    end else if (st_neg4_r) begin
      st_v_c = STEER_W'(ST_LOW_V) + st_q4_r;
    end else begin
      st_v_c = STEER_W'(ST_LOW_V) - st_q4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stv_r[5] <= st_v_c;
      for (int k = 6; k <= PIPE_LAST; k++) begin
        stv_r[k] <= stv_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // throttle scale: (w - from) * 120 / span, restoring division, one quotient
  // bit per stage; the width never passes max_pulse so the quotient fits 7 bits
  // ---------------------------------------------------------------------------
  logic [THR_NUM_W-1:0] rem_r [0:THR_Q_W];
  logic [THR_Q_W-1:0]   quo_r [0:THR_Q_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= THR_NUM_W'(thw1_r - thr_from_r) * THR_NUM_W'(THR_MAX);
      quo_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= THR_Q_W; k++) begin : g_div
    localparam int B = THR_Q_W - k;
    logic [THR_NUM_W-1:0] cand;
    logic                 ge;

    assign cand = THR_NUM_W'(span_r) << B;
    assign ge   = rem_r[k-1] >= cand;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? (rem_r[k-1] - cand) : rem_r[k-1];
        quo_r[k] <= quo_r[k-1] | (THR_Q_W'(ge) << B);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register; the held command values are the result payload
  // ---------------------------------------------------------------------------
  logic [STEER_W-1:0]      steering_r;
  logic signed [THR_W-1:0] throttle_r;
  logic                    out_fresh_s_r;
  logic                    out_fresh_t_r;
  logic [STEER_W-1:0]      steering_nxt;
  logic signed [THR_W-1:0] throttle_nxt;

  always_comb begin
    steering_nxt = ctl_r[PIPE_LAST].st_upd ? stv_r[PIPE_LAST] : steering_r;
    if (ctl_r[PIPE_LAST].th_brake) begin
      throttle_nxt = THR_BRAKE;
    end else if (ctl_r[PIPE_LAST].th_map) begin
      throttle_nxt = (span_r == '0) ? '0 : $signed({1'b0, quo_r[THR_Q_W]});
    end else begin
      throttle_nxt = throttle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      steering_r  <= '0;
      throttle_r  <= '0;
    end else if (adv) begin
      out_valid_r <= vld_r[PIPE_LAST];
      if (vld_r[PIPE_LAST]) begin
        steering_r <= steering_nxt;
        throttle_r <= throttle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[PIPE_LAST]) begin
      out_fresh_s_r <= ctl_r[PIPE_LAST].fresh_s;
      out_fresh_t_r <= ctl_r[PIPE_LAST].fresh_t;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.steering_value = steering_r;
  assign out_ch.throttle_value = throttle_r;
  assign out_ch.steering_fresh = out_fresh_s_r;
  assign out_ch.throttle_fresh = out_fresh_t_r;
  assign out_ch.all_valid      = out_fresh_s_r && out_fresh_t_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the map can never exceed the top of the low segment
  `RCPWD_ASSERT(a_steer_bound, clk, rst_n, steering_r <= STEER_W'(ST_V_MAX))
  // an item at the pipe end is not dropped while the output is stalled
  `RCPWD_ASSERT(a_tail_held, clk, rst_n, vld_r[PIPE_LAST] && !adv |=> vld_r[PIPE_LAST])
  // reset empties the output register
  `RCPWD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid_r)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rcpwd_pkg::*;

  // run shape
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 16;   // covers the pipeline latency plus margin
  localparam int RANDOM_PHASES   = 8;
  localparam int FIXED_PHASES    = 4;
  localparam int TICKS_PER_PHASE = 128;
  localparam int HOLD_CYCLES     = 400;
  localparam int N_DIR_ROWS      = 22;
  localparam int MAX_PRINTS      = 40;
  localparam int STEER_TOP       = (1 << STEER_W) - 1;

  // one decoded item as it leaves the block
  typedef struct packed {
    logic [STEER_W-1:0]      steering;
    logic signed [THR_W-1:0] throttle;
    logic                    steer_fresh;
    logic                    thr_fresh;
    logic                    both_fresh;
  } decoded_t;

  // register set, in index order
  typedef struct packed {
    logic [CFG_DATA_W-1:0] steer_int;
    logic [CFG_DATA_W-1:0] thr_int;
    logic [CFG_DATA_W-1:0] min_w;
    logic [CFG_DATA_W-1:0] max_w;
    logic [CFG_DATA_W-1:0] brake_w;
    logic [CFG_DATA_W-1:0] from_w;
  } settings_t;

  // a run of identical ticks; the typed result, if any, applies to its last tick
  typedef struct packed {
    int       len;
    bit       steer;
    bit       thr;
    bit       clr;
    bit       typed;
    decoded_t want;
  } pin_run_t;

  logic clk;
  logic rst_n;

  rcpwd_in_if  in_if ();
  rcpwd_out_if out_if ();
  rcpwd_cfg_if cfg_if ();

  rc_pulse_width_decoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // clock: 4 ns period
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoder state as the block should hold it
  // ---------------------------------------------------------------------------
  settings_t                  set_q;
  logic [TIME_BITS_DEF-1:0]   tick_now;
  logic [1:0]                 pin_q;
  logic [1:0]                 armed_q;
  logic [TIME_BITS_DEF-1:0]   rise_at [2];
  logic [PW_W-1:0]            width_q [2];
  logic [PW_W-1:0]            last_width [2];
  logic [TIME_BITS_DEF-1:0]   update_at [2];
  logic [STEER_W-1:0]         steer_cmd;
  logic signed [THR_W-1:0]    thr_cmd;
  logic [1:0]                 fresh_q;

  // decoded items still owed by the block, oldest first
  decoded_t pending_decodes [$];

  int errors          = 0;
  int results_checked = 0;
  int dir_ticks       = 0;
  int rnd_ticks       = 0;
  int idle_pct        = 0;
  int stall_pct       = 0;
  int hold_request    = 0;
  int hold_left       = 0;

  // pulse train generator state, one lane per channel
  logic [1:0] gen_lvl       = 2'b00;
  int         gen_left  [2] = '{0, 0};
  int         gen_width [2] = '{1, 1};
  int         gen_reps  [2] = '{0, 0};
  int         width_cap     = 8;

  // directed register set: no intervals so every tick may update, wide pulse window
  settings_t directed_set = '{16'd0, 16'd0, 16'd10, 16'd65535, 16'd20, 16'd30};

  // fixed random-phase settings, then random ones
  settings_t fixed_sets [FIXED_PHASES] = '{
    '{16'd3,     16'd5, 16'd2, 16'd30,    16'd8,     16'd12},  // plain small windows
    '{16'd0,     16'd1, 16'd1, 16'd25,    16'd12,    16'd8},   // brake band over throttle band
    '{16'd7,     16'd11, 16'd3, 16'd20,   16'd6,     16'd20},  // throttle_from equals max_pulse
    '{16'd65535, 16'd1, 16'd0, 16'd65535, 16'd65535, 16'd0}    // register extremes
  };

  // directed runs; widths are set by how long a level is held
  pin_run_t dir_runs [N_DIR_ROWS] = '{
    // straight after reset nothing is valid yet
    '{1,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd0, 8'sd0, 1'b0, 1'b0, 1'b0}},
    '{15,    1'b1, 1'b1, 1'b0, 1'b0, '0},
    // first in-range width: flags set, nothing mapped yet
    '{1,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd0, 8'sd0, 1'b1, 1'b1, 1'b1}},
    // same width again: steering mapped, throttle below brake_below brakes; clear
    '{1,     1'b0, 1'b0, 1'b1, 1'b1, '{10'd911, THR_BRAKE, 1'b1, 1'b1, 1'b1}},
    '{1,     1'b0, 1'b0, 1'b0, 1'b0, '0},
    // throttle between brake and throttle bands keeps the old value
    '{25,    1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b0, '0},
    // too short on both channels
    '{5,     1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{3,     1'b0, 1'b0, 1'b0, 1'b0, '0},
    // steering at the knee
    '{1440,  1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd722, THR_BRAKE, 1'b1, 1'b1, 1'b1}},
    // one past the knee, quotient truncates toward zero
    '{1441,  1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b0, '0},
    // upper calibration point
    '{1860,  1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd639, THR_BRAKE, 1'b1, 1'b1, 1'b1}},
    // lower calibration point
    '{1012,  1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd779, THR_BRAKE, 1'b1, 1'b1, 1'b1}},
    // throttle exactly at throttle_from
    '{30,    1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd779, 8'sd0, 1'b1, 1'b1, 1'b1}},
    // both widths saturate: steering clamps low, throttle at full scale
    '{70000, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{2,     1'b0, 1'b0, 1'b0, 1'b1, '{10'd0, 8'sd120, 1'b1, 1'b1, 1'b1}},
    '{1,     1'b0, 1'b0, 1'b1, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // decoder behaviour
  // ---------------------------------------------------------------------------
  function automatic void model_reset();
    set_q     = '{RST_STEER_INTERVAL, RST_THROTTLE_INTERVAL, RST_MIN_PULSE,
                  RST_MAX_PULSE, RST_BRAKE_BELOW, RST_THROTTLE_FROM};
    tick_now  = '0;
    pin_q     = '0;
    armed_q   = '0;
    fresh_q   = '0;
    steer_cmd = '0;
    thr_cmd   = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      rise_at[ch]    = '0;
      width_q[ch]    = '0;
      last_width[ch] = '0;
      update_at[ch]  = '0;
    end
  endfunction

  // edge detect: stamp on rise, measure on a fall that follows a rise
  function automatic void sense_pin(int ch, logic lvl);
    logic [TIME_BITS_DEF-1:0] held;
    if (lvl && !pin_q[ch]) begin
      rise_at[ch] = tick_now;
      armed_q[ch] = 1'b1;
    end else if (!lvl && pin_q[ch] && armed_q[ch]) begin
      held        = tick_now - rise_at[ch];
      width_q[ch] = (held > 65535) ? 16'hffff : held[PW_W-1:0];
      armed_q[ch] = 1'b0;
    end
    pin_q[ch] = lvl;
  endfunction

  // interval gate and range check; an accepted width refreshes stamp and flag
  function automatic bit take_width(int ch, logic [CFG_DATA_W-1:0] interval,
                                    output logic [PW_W-1:0] w, output bit repeated);
    logic [TIME_BITS_DEF-1:0] elapsed;
    elapsed  = tick_now - update_at[ch];
    w        = width_q[ch];
    repeated = 1'b0;
    if (elapsed < interval) return 1'b0;
    if (w < set_q.min_w || w > set_q.max_w) return 1'b0;
    repeated       = (last_width[ch] == w);
    update_at[ch]  = tick_now;
    last_width[ch] = w;
    fresh_q[ch]    = 1'b1;
    return 1'b1;
  endfunction

  // two calibrated segments, knee at 1440, signed quotient truncates toward zero
  function automatic logic [STEER_W-1:0] steer_from_width(logic [PW_W-1:0] w);
    int x;
    int v;
    x = int'(w);
    if (x <= ST_KNEE_W)
      v = ST_LOW_V + ((x - ST_LOW_W) * (ST_KNEE_V - ST_LOW_V)) / (ST_KNEE_W - ST_LOW_W);
    else
      v = ST_KNEE_V + ((x - ST_KNEE_W) * (ST_HIGH_V - ST_KNEE_V)) / (ST_HIGH_W - ST_KNEE_W);
    if (v < 0) v = 0;
    if (v > STEER_TOP) v = STEER_TOP;
    return v[STEER_W-1:0];
  endfunction

  // brake test first; between the bands the old value stays
  function automatic void throttle_from_width(logic [PW_W-1:0] w);
    int span;
    if (w < set_q.brake_w) begin
      thr_cmd = THR_BRAKE;
    end else if (w >= set_q.from_w) begin
      span = (set_q.max_w > set_q.from_w) ? int'(set_q.max_w) - int'(set_q.from_w) : 0;
      if (span != 0)
        thr_cmd = THR_W'(((int'(w) - int'(set_q.from_w)) * THR_MAX) / span);
      else
        thr_cmd = '0;
    end
  endfunction

  // one microsecond tick in, one decoded item out
  function automatic decoded_t decode_tick(logic s, logic t, logic clr);
    decoded_t         r;
    logic [PW_W-1:0]  w;
    bit               rep;
    sense_pin(CH_STEER, s);
    sense_pin(CH_THR, t);
    if (take_width(CH_THR, set_q.thr_int, w, rep) && rep) throttle_from_width(w);
    if (take_width(CH_STEER, set_q.steer_int, w, rep) && rep) steer_cmd = steer_from_width(w);
    r.steering    = steer_cmd;
    r.throttle    = thr_cmd;
    r.steer_fresh = fresh_q[CH_STEER];
    r.thr_fresh   = fresh_q[CH_THR];
    r.both_fresh  = fresh_q[CH_STEER] & fresh_q[CH_THR];
    // flags show before a clear on the same tick
    if (clr) fresh_q = '0;
    tick_now = tick_now + 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_STEER_INTERVAL:    set_q.steer_int = val;
      REG_THROTTLE_INTERVAL: set_q.thr_int   = val;
      REG_MIN_PULSE:         set_q.min_w     = val;
      REG_MAX_PULSE:         set_q.max_w     = val;
      REG_BRAKE_BELOW:       set_q.brake_w   = val;
      REG_THROTTLE_FROM:     set_q.from_w    = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(REG_STEER_INTERVAL,    s.steer_int);
    write_reg(REG_THROTTLE_INTERVAL, s.thr_int);
    write_reg(REG_MIN_PULSE,         s.min_w);
    write_reg(REG_MAX_PULSE,         s.max_w);
    write_reg(REG_BRAKE_BELOW,       s.brake_w);
    write_reg(REG_THROTTLE_FROM,     s.from_w);
    cfg_if.valid <= 1'b0;
  endtask

  // offer one tick, with random gaps first; predict once it is taken
  task automatic send_tick(logic s, logic t, logic c, bit typed, decoded_t want);
    decoded_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.steer_level    <= s;
    in_if.throttle_level <= t;
    in_if.clear_flags    <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = decode_tick(s, t, c);
    pending_decodes.push_back(typed ? want : pred);
  endtask

  // stop offering, let every owed item arrive, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly repeated pulses of random width, with some pin noise
  task automatic next_random_tick(output logic s, output logic t, output logic c);
    logic [1:0] lv;
    for (int ch = 0; ch < NCH; ch++) begin
      if (gen_left[ch] == 0) begin
        if (gen_lvl[ch]) begin
          gen_lvl[ch]  = 1'b0;
          gen_left[ch] = $urandom_range(8, 1);
        end else begin
          if (gen_reps[ch] == 0) begin
            gen_width[ch] = $urandom_range(width_cap, 1);
            gen_reps[ch]  = $urandom_range(3, 1);
          end
          gen_reps[ch]--;
          gen_lvl[ch]  = 1'b1;
          gen_left[ch] = gen_width[ch];
        end
      end
      gen_left[ch]--;
      // a stray level now and then breaks a pulse
      lv[ch] = ($urandom_range(99) < 8) ? 1'($urandom_range(1)) : gen_lvl[ch];
    end
    s = lv[CH_STEER];
    t = lv[CH_THR];
    c = ($urandom_range(99) < 10);
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random stalls, plus a long hold on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
  endtask

  // compare every item taken off the output against the oldest owed one
  always @(posedge clk) begin : result_check
    decoded_t got;
    decoded_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.steering    = out_if.steering_value;
      got.throttle    = out_if.throttle_value;
      got.steer_fresh = out_if.steering_fresh;
      got.thr_fresh   = out_if.throttle_fresh;
      got.both_fresh  = out_if.all_valid;
      if (pending_decodes.size() == 0) begin
        report_mismatch("item with none owed, steering_value", int'(got.steering), 0);
      end else begin
        want = pending_decodes.pop_front();
        results_checked++;
        if (got.steering !== want.steering)
          report_mismatch("steering_value", int'(got.steering), int'(want.steering));
        if (got.throttle !== want.throttle)
          report_mismatch("throttle_value", int'(got.throttle), int'(want.throttle));
        if (got.steer_fresh !== want.steer_fresh)
          report_mismatch("steering_fresh", int'(got.steer_fresh), int'(want.steer_fresh));
        if (got.thr_fresh !== want.thr_fresh)
          report_mismatch("throttle_fresh", int'(got.thr_fresh), int'(want.thr_fresh));
        if (got.both_fresh !== want.both_fresh)
          report_mismatch("all_valid", int'(got.both_fresh), int'(want.both_fresh));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("rc_pulse_width_decoder_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    settings_t cfg;
    logic      s;
    logic      t;
    logic      c;

    // everything known from time zero
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.steer_level    = 1'b0;
    in_if.throttle_level = 1'b0;
    in_if.clear_flags    = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    out_if.ready         = 1'b0;
    model_reset();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed runs, no idling on either side
    apply_settings(directed_set);
    for (int r = 0; r < N_DIR_ROWS; r++) begin
      for (int n = 0; n < dir_runs[r].len; n++) begin
        send_tick(dir_runs[r].steer, dir_runs[r].thr, dir_runs[r].clr,
                  dir_runs[r].typed && (n == dir_runs[r].len - 1), dir_runs[r].want);
        dir_ticks++;
      end
    end

    // random pulse trains, new settings and a new idling mix per phase
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      if (ph < FIXED_PHASES) begin
        cfg = fixed_sets[ph];
      end else begin
        cfg.steer_int = $urandom_range(12, 0);
        cfg.thr_int   = $urandom_range(20, 0);
        cfg.min_w     = $urandom_range(6, 0);
        cfg.max_w     = $urandom_range(44, cfg.min_w);
        cfg.brake_w   = $urandom_range(48, 0);
        cfg.from_w    = $urandom_range(48, 0);
      end
      apply_settings(cfg);
      width_cap = (cfg.max_w > 44) ? 48 : int'(cfg.max_w) + 4;
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct  = 38;
          stall_pct = 38;
        end
      endcase
      // long back-pressure while items keep coming, so the pipe fills up
      if (ph == 2) hold_request = HOLD_CYCLES;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        next_random_tick(s, t, c);
        send_tick(s, t, c, 1'b0, '0);
        rnd_ticks++;
      end
    end
    drain();

    $display("ran %0d directed ticks (knee, calibration points, saturation) and %0d random",
             dir_ticks, rnd_ticks);
    $display("ticks over %0d register sets; %0d decoded items compared, %0d errors",
             RANDOM_PHASES + 1, results_checked, errors);
    if (errors == 0)
      $display("rc_pulse_width_decoder_top: match");
    else
      $display("rc_pulse_width_decoder_top: mismatch");
    $finish;
  end

endmodule
